// ----- hdl/aalu_pkg.sv -----
`timescale 1ns / 1ps
// Package for the accumulator ALU with flags.
// Holds the operation codes and the default accumulator width; no dependencies.
package aalu_pkg;

  localparam int unsigned AccWidthDefault = 20;
  localparam int unsigned ModeWidth       = 4;
  localparam int unsigned ShiftWidth      = 7;

  typedef enum logic [ModeWidth-1:0] {
    MODE_PASS   = 4'd0,
    MODE_ADD    = 4'd1,
    MODE_NAND   = 4'd2,
    MODE_SUB    = 4'd3,
    MODE_AND    = 4'd4,
    MODE_OR     = 4'd5,
    MODE_XOR    = 4'd6,
    MODE_NOT    = 4'd7,
    MODE_NEGATE = 4'd8,
    MODE_SHIFT  = 4'd9,
    MODE_MUL    = 4'd10
  } mode_e;

  // Bit positions in the flag register.
  localparam int unsigned FlagZ = 0;
  localparam int unsigned FlagC = 1;
  localparam int unsigned FlagO = 2;
  localparam int unsigned FlagN = 3;

endpackage

// ----- hdl/accumulator_alu_with_flags_top.sv -----
`timescale 1ns / 1ps
// Accumulator ALU with Z, C, O and N flags: input register, one-pass ALU, state register.
// Depends on aalu_pkg for operation codes and defaults.
//
//  channel  | direction | payload (lowest bit first)
//  ---------+-----------+------------------------------------------------------
//  s_axis   | in        | mode[3:0], operand[WIDTH-1:0], shift_count[6:0], zero pad
//  m_axis   | out       | acc_value[WIDTH-1:0], zero, carry, overflow, negative, pad
//
// One item per cycle is sustained unless downstream stalls; an item passes first
// through the input register, then through the ALU into the accumulator.
// The accumulator and flag registers double as the output register, so a result is
// held stable for as long as the downstream side stalls.
// Reset clears the accumulator, the flags and both valid bits; no clearing pass.
// A stall downstream holds the input register, and the upstream side waits only
// when both the input register and the result are occupied.
module accumulator_alu_with_flags_top
  import aalu_pkg::*;
#(
  parameter int unsigned WIDTH = AccWidthDefault,
  localparam int unsigned InBits   = ModeWidth + WIDTH + ShiftWidth,
  localparam int unsigned InWidth  = ((InBits + 7) / 8) * 8,
  localparam int unsigned OutBits  = WIDTH + 4,
  localparam int unsigned OutWidth = ((OutBits + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // mode[3:0], operand[WIDTH+3:4], shift_count[WIDTH+10:WIDTH+4], zero pad above
  input  logic [InWidth-1:0]    s_axis_tdata_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // acc_value[WIDTH-1:0], flag_zero, flag_carry, flag_overflow, flag_negative, zero pad
  output logic [OutWidth-1:0]   m_axis_tdata_o
);

  typedef struct packed {
    logic             carry;
    logic             overflow;
    logic [WIDTH-1:0] sum;
  } add_res_t;

  function automatic add_res_t add_f(input logic [WIDTH-1:0] x, input logic [WIDTH-1:0] y);
    logic [WIDTH:0] full;
    add_res_t       res;
    full         = {1'b0, x} + {1'b0, y};
    res.sum      = full[WIDTH-1:0];
    res.carry    = full[WIDTH];
    res.overflow = (x[WIDTH-1] == y[WIDTH-1]) && (full[WIDTH-1] != x[WIDTH-1]);
    return res;
  endfunction

  // Input register.
  logic                  in_valid_q;
  logic [ModeWidth-1:0]  mode_q;
  logic [WIDTH-1:0]      operand_q;
  logic [ShiftWidth-1:0] shift_q;

  // State, which is also the output register.
  logic                  out_valid_q;
  logic [WIDTH-1:0]      acc_q, acc_d;
  logic [3:0]            flags_q, flags_d;

  logic                  out_free;
  logic                  advance;
  logic                  in_take;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign advance         = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      mode_q    <= s_axis_tdata_i[ModeWidth-1:0];
      operand_q <= s_axis_tdata_i[ModeWidth +: WIDTH];
      shift_q   <= s_axis_tdata_i[ModeWidth+WIDTH +: ShiftWidth];
    end
  end

  // ALU datapath.
  add_res_t              add_res, sub_res, neg_res, dbl_res;
  logic [WIDTH-1:0]      neg_b;
  logic [WIDTH-1:0]      shl_pre;
  logic [WIDTH-1:0]      shr_res;
  logic [WIDTH-1:0]      mul_res;
  logic [ShiftWidth-1:0] shl_amt;
  logic [ShiftWidth-1:0] shr_amt;
  logic [WIDTH-1:0]      res;
  logic                  c_new, o_new;
  logic                  upd;

  assign neg_b   = WIDTH'(~operand_q + 1'b1);
  assign add_res = add_f(acc_q, operand_q);
  assign sub_res = add_f(neg_b, acc_q);
  assign neg_res = add_f(~acc_q, WIDTH'(1));
  // A left shift by n is n-1 plain shifts and a final doubling that sets C and O.
  assign shl_amt = shift_q - 1'b1;
  assign shl_pre = acc_q << shl_amt;
  assign dbl_res = add_f(shl_pre, shl_pre);
  assign shr_amt = ShiftWidth'(~shift_q + 1'b1);
  assign shr_res = acc_q >> shr_amt;
  assign mul_res = WIDTH'(acc_q * operand_q);

  always_comb begin
    res   = acc_q;
    c_new = flags_q[FlagC];
    o_new = flags_q[FlagO];
    upd   = 1'b1;
    case (mode_e'(mode_q))
      MODE_PASS:   res = operand_q;
      MODE_ADD:    begin
        res   = add_res.sum;
        c_new = add_res.carry;
        o_new = add_res.overflow;
      end
      MODE_NAND:   res = ~(acc_q & operand_q);
      MODE_SUB:    begin
        res   = sub_res.sum;
        c_new = sub_res.carry;
        o_new = sub_res.overflow;
      end
      MODE_AND:    res = acc_q & operand_q;
      MODE_OR:     res = acc_q | operand_q;
      MODE_XOR:    res = acc_q ^ operand_q;
      MODE_NOT:    res = ~acc_q;
      MODE_NEGATE: begin
        res   = neg_res.sum;
        c_new = neg_res.carry;
        o_new = neg_res.overflow;
      end
      MODE_SHIFT:  begin
        if (shift_q[ShiftWidth-1]) begin
          res = shr_res;
        end else if (shift_q != '0) begin
          res   = dbl_res.sum;
          c_new = dbl_res.carry;
          o_new = dbl_res.overflow;
        end
      end
      MODE_MUL:    begin
        res   = mul_res;
        c_new = acc_q[0];
        o_new = acc_q[0];
      end
      default:     upd = 1'b0;
    endcase
  end

  always_comb begin
    acc_d   = acc_q;
    flags_d = flags_q;
    if (advance && upd) begin
      acc_d          = res;
      flags_d[FlagZ] = (res == '0);
      flags_d[FlagC] = c_new;
      flags_d[FlagO] = o_new;
      flags_d[FlagN] = res[WIDTH-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      acc_q       <= '0;
      flags_q     <= '0;
    end else begin
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      acc_q   <= acc_d;
      flags_q <= flags_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutWidth'({flags_q[FlagN], flags_q[FlagO], flags_q[FlagC],
                                      flags_q[FlagZ], acc_q});

`ifndef ASSERT_OFF
  // An item leaving the input register always lands as a valid result.
  a_advance_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("item left the input register without producing a result");

  // The state only changes when an item is processed.
  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(acc_q) && $stable(flags_q))
    else $error("accumulator changed without an item being processed");

  // Unused operation codes leave the accumulator and every flag untouched.
  a_unused_mode_noop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (mode_q > MODE_MUL)) |=> $stable(acc_q) && $stable(flags_q))
    else $error("unused mode modified the state");

  // The negative flag always mirrors the top bit of the accumulator.
  a_negative_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags_q[FlagN] == acc_q[WIDTH-1])
    else $error("negative flag disagrees with accumulator");

  // A stalled input item is not lost while the result waits.
  a_input_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_free) |=> in_valid_q && $stable(mode_q) && $stable(operand_q))
    else $error("pending input item was dropped during a stall");
`endif

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for accumulator_alu_with_flags_top over its stream ports.
// Depends on aalu_pkg and the top level; a scoreboard class predicts every result.
module tb;
  import aalu_pkg::*;

  localparam int unsigned WIDTH      = 20;
  localparam int unsigned InWidth    = 32;
  localparam int unsigned OutWidth   = 24;
  localparam int          CycleLimit = 200000;

  typedef logic [WIDTH-1:0] word_t;

  // Keeps its own accumulator and flags and queues the result each item must produce.
  class acc_scoreboard;
    word_t               acc;
    logic                zf, cf, of, nf;
    logic [OutWidth-1:0] expected_q[$];
    int                  errors;

    function new();
      acc    = '0;
      zf     = 1'b0;
      cf     = 1'b0;
      of     = 1'b0;
      nf     = 1'b0;
      errors = 0;
    endfunction

    function word_t add_with_flags(input word_t a, input word_t b,
                                   output logic carry, output logic ovf);
      logic [WIDTH:0] sum;
      sum   = {1'b0, a} + {1'b0, b};
      carry = sum[WIDTH];
      ovf   = (a[WIDTH-1] == b[WIDTH-1]) && (sum[WIDTH-1] != a[WIDTH-1]);
      return sum[WIDTH-1:0];
    endfunction

    function void note_item(input logic [InWidth-1:0] item);
      logic [ModeWidth-1:0]         mode;
      word_t                        b, r, ap;
      logic signed [ShiftWidth-1:0] sc;
      int                           n;
      logic                         c, o, update;
      mode   = item[3:0];
      b      = item[WIDTH+3:4];
      sc     = item[WIDTH+10:WIDTH+4];
      n      = sc;
      r      = acc;
      c      = cf;
      o      = of;
      update = 1'b1;
      case (mode)
        MODE_PASS:   r = b;
        MODE_ADD:    r = add_with_flags(acc, b, c, o);
        MODE_NAND:   r = ~(acc & b);
        MODE_SUB:    r = add_with_flags(-b, acc, c, o);
        MODE_AND:    r = acc & b;
        MODE_OR:     r = acc | b;
        MODE_XOR:    r = acc ^ b;
        MODE_NOT:    r = ~acc;
        MODE_NEGATE: r = add_with_flags(~acc, word_t'(1), c, o);
        MODE_SHIFT: begin
          // A left shift is a run of doublings; only the last one sets the flags.
          if (n > 0) begin
            ap = (n - 1 < WIDTH) ? (acc << (n - 1)) : '0;
            r  = add_with_flags(ap, ap, c, o);
          end else if (n < 0) begin
            r = (-n >= WIDTH) ? '0 : (acc >> (-n));
          end
        end
        MODE_MUL: begin
          r = acc * b;
          c = acc[0];
          o = acc[0];
        end
        default: update = 1'b0;
      endcase
      if (update) begin
        acc = r;
        zf  = (r == '0);
        cf  = c;
        of  = o;
        nf  = r[WIDTH-1];
      end
      expected_q.push_back({nf, of, cf, zf, acc});
    endfunction

    function void check_result(input logic [OutWidth-1:0] got);
      logic [OutWidth-1:0] want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got[WIDTH-1:0] !== want[WIDTH-1:0]) begin
        $display("%0t: acc_value expected %h actual %h", $time, want[WIDTH-1:0],
                 got[WIDTH-1:0]);
        errors++;
      end
      if (got[WIDTH] !== want[WIDTH]) begin
        $display("%0t: flag_zero expected %b actual %b", $time, want[WIDTH], got[WIDTH]);
        errors++;
      end
      if (got[WIDTH+1] !== want[WIDTH+1]) begin
        $display("%0t: flag_carry expected %b actual %b", $time, want[WIDTH+1],
                 got[WIDTH+1]);
        errors++;
      end
      if (got[WIDTH+2] !== want[WIDTH+2]) begin
        $display("%0t: flag_overflow expected %b actual %b", $time, want[WIDTH+2],
                 got[WIDTH+2]);
        errors++;
      end
      if (got[WIDTH+3] !== want[WIDTH+3]) begin
        $display("%0t: flag_negative expected %b actual %b", $time, want[WIDTH+3],
                 got[WIDTH+3]);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InWidth-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutWidth-1:0] m_axis_tdata;

  int            src_idle_pct;
  int            sink_stall_pct;
  int            cycle_count;
  acc_scoreboard sb;

  accumulator_alu_with_flags_top #(
    .WIDTH(WIDTH)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // The receiver decides its stall afresh at every falling edge.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_item(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_item(input logic [ModeWidth-1:0] mode, input word_t operand,
                           input logic [ShiftWidth-1:0] shift_count);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, shift_count, operand, mode};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic send_random_item();
    logic [ModeWidth-1:0] mode;
    word_t                operand;
    int                   pick;
    pick = $urandom_range(0, 19);
    mode = (pick == 0) ? ModeWidth'($urandom_range(11, 15)) : ModeWidth'($urandom_range(0, 10));
    case ($urandom_range(0, 7))
      0:       operand = {1'b0, {(WIDTH-1){1'b1}}};
      1:       operand = {1'b1, {(WIDTH-1){1'b0}}};
      2:       operand = ($urandom_range(0, 1) != 0) ? '1 : '0;
      3:       operand = word_t'($urandom_range(0, 3));
      default: operand = word_t'($urandom());
    endcase
    send_item(mode, operand, ShiftWidth'($urandom_range(0, 64) - 32));
  endtask

  initial begin
    sb             = new();
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    m_axis_tready  = 1'b0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    cycle_count    = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed items: operand extremes, every operation and the shift corner cases.
    send_item(MODE_PASS, 20'h7FFFF, 7'sd0);
    send_item(MODE_ADD, 20'h00001, 7'sd0);      // signed overflow
    send_item(MODE_PASS, 20'hFFFFF, 7'sd0);
    send_item(MODE_ADD, 20'h00001, 7'sd0);      // carry out, zero result
    send_item(MODE_SUB, 20'h00000, 7'sd0);
    send_item(MODE_SUB, 20'h80000, 7'sd0);
    send_item(MODE_NAND, 20'hA5A5A, 7'sd0);
    send_item(MODE_AND, 20'h0F0F0, 7'sd0);
    send_item(MODE_OR, 20'h80001, 7'sd0);
    send_item(MODE_XOR, 20'hFFFFF, 7'sd0);
    send_item(MODE_NOT, 20'h00000, 7'sd0);
    send_item(MODE_PASS, 20'h80000, 7'sd0);
    send_item(MODE_NEGATE, 20'h00000, 7'sd0);   // most negative value negates to itself
    send_item(MODE_PASS, 20'hC0001, 7'sd0);
    send_item(MODE_SHIFT, 20'h00000, 7'sd0);
    send_item(MODE_SHIFT, 20'h00000, 7'sd1);
    send_item(MODE_SHIFT, 20'h00000, -7'sd1);
    send_item(MODE_PASS, 20'h00003, 7'sd0);
    send_item(MODE_SHIFT, 20'h00000, 7'sd19);
    send_item(MODE_PASS, 20'hFFFFF, 7'sd0);
    send_item(MODE_SHIFT, 20'h00000, 7'sd20);
    send_item(MODE_SHIFT, 20'h00000, 7'sd32);   // shifted past the width: zero result, only Z set
    send_item(MODE_PASS, 20'h80000, 7'sd0);
    send_item(MODE_SHIFT, 20'h00000, -7'sd19);
    send_item(MODE_SHIFT, 20'h00000, -7'sd32);
    send_item(MODE_PASS, 20'h00005, 7'sd0);
    send_item(MODE_MUL, 20'hFFFFF, 7'sd0);
    send_item(4'd11, 20'h12345, 7'sd5);
    send_item(4'd15, 20'hFFFFF, -7'sd20);

    // Random items over four idling phases.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 52; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 52; end
        default: begin src_idle_pct = 20; sink_stall_pct = 20; end
      endcase
      repeat (162) send_random_item();
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
